### rtl/core/sfmt_pkg.sv
// Package: shared types and constants of the SFMT word generator.
package sfmt_pkg;

    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    localparam logic [31:0] SEED_MULT  = 32'd1812433253;
    localparam logic [31:0] RESET_SEED = 32'd1234;

    localparam logic [2:0] REG_MASK0   = 3'd0;
    localparam logic [2:0] REG_PARITY0 = 3'd4;

    localparam logic [31:0] MASK0_RST   = 32'hdfffffef;
    localparam logic [31:0] MASK1_RST   = 32'hddfecb7f;
    localparam logic [31:0] MASK2_RST   = 32'hbffaffff;
    localparam logic [31:0] MASK3_RST   = 32'hbffffff6;
    localparam logic [31:0] PARITY0_RST = 32'h00000001;
    localparam logic [31:0] PARITY1_RST = 32'h00000000;
    localparam logic [31:0] PARITY2_RST = 32'h00000000;
    localparam logic [31:0] PARITY3_RST = 32'h13c9e684;

    // datapath operation selected by the controller
    typedef enum logic [2:0] {
        DP_NOP,
        DP_SEED_START,   // load seed as word 0
        DP_SEED_STEP,    // multiply step of the seed recurrence
        DP_SEED_WRITE,   // finish word, write lane into entry
        DP_CERT,         // period certification on entry 0
        DP_REGEN_READ,   // issue reads for one recursion step
        DP_REGEN_WRITE,  // write the new entry
        DP_DRAW          // read and return one word
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   first;   // first item of a sweep
    } dp_cmd_t;

    typedef struct packed {
        logic seed_done;   // last word of the fill written
        logic regen_done;  // last entry of a sweep written
        logic need_regen;  // every word has been read, or the state was just seeded
        logic word_valid;  // draw read data is on the RAM read port
    } dp_status_t;

endpackage

### rtl/core/sfmt_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module sfmt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 156
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

### rtl/core/sfmt_datapath.sv
// Datapath: state RAM, seed recurrence, certification and SFMT recursion.
module sfmt_datapath #(
    parameter int STORE_DEPTH      = 156,
    parameter int PICK_OFFSET      = 122,
    parameter int WORD_SHIFT_LEFT  = 18,
    parameter int BYTE_SHIFT_LEFT  = 1,
    parameter int WORD_SHIFT_RIGHT = 11,
    parameter int BYTE_SHIFT_RIGHT = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfmt_pkg::dp_cmd_t    cmd,
    output sfmt_pkg::dp_status_t status,
    input  logic [31:0]          seed,
    input  logic [127:0]         masks,
    input  logic [127:0]         parities,
    output logic [31:0]          word
);
    import sfmt_pkg::*;

    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int WORDS = 4 * STORE_DEPTH;
    localparam int PW    = $clog2(WORDS + 1);
    localparam int WAW   = $clog2(WORDS);
    localparam int PICK  = PICK_OFFSET % STORE_DEPTH;
    localparam int BL    = BYTE_SHIFT_LEFT * 8;
    localparam int BR    = BYTE_SHIFT_RIGHT * 8;
    localparam logic [AW-1:0] LAST_ENTRY = AW'(STORE_DEPTH - 1);
    localparam logic [AW-1:0] PRELAST    = AW'(STORE_DEPTH - 2);
    localparam logic [AW-1:0] PICK_A     = AW'(PICK);
    localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);
    localparam logic [PW-1:0] WORDS_P    = PW'(WORDS);

    logic           we;
    logic [AW-1:0]  waddr, raddr_a, raddr_b;
    logic [127:0]   wdata, rdata_a, rdata_b;

    sfmt_ram #(.WIDTH(128), .DEPTH(STORE_DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr_a(raddr_a), .rdata_a(rdata_a),
        .raddr_b(raddr_b), .rdata_b(rdata_b)
    );

    // seed fill registers
    logic [WAW-1:0] widx_reg, widx_next;     // index of word in prev_reg
    logic [31:0]    prev_reg, prev_next;     // last finished word
    logic [31:0]    prod_reg, prod_next;     // multiply product
    logic [95:0]    lanes_reg, lanes_next;   // lanes 0..2 of entry
    logic [127:0]   e0_reg, e0_next;         // entry 0 copy for certification
    // recursion registers
    logic [AW-1:0]  ri_reg, ri_next;
    logic [AW-1:0]  bi_reg, bi_next;
    logic [127:0]   r1_reg, r1_next, r2_reg, r2_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic           wvalid_reg, wvalid_next;
    logic           sdone_reg, sdone_next, gdone_reg, gdone_next;
    logic [1:0]     dsel_reg;
    logic [127:0]   r1_pre, r2_pre;

    logic [31:0]  mixed;
    logic [127:0] newe, ax, cy, certe, pand;
    logic         par;
    logic [127:0] flip;
    logic [1:0]   wsel;

    assign mixed = prev_reg ^ (prev_reg >> 30);

    // SFMT recursion: a = rdata_a, b = rdata_b, c = r1, d = r2
    assign ax = rdata_a << BL;
    assign cy = r1_reg >> BR;
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            newe[32*j +: 32] = rdata_a[32*j +: 32] ^ ax[32*j +: 32] ^ cy[32*j +: 32]
                ^ ((rdata_b[32*j +: 32] >> WORD_SHIFT_RIGHT) & masks[32*j +: 32])
                ^ (r2_reg[32*j +: 32] << WORD_SHIFT_LEFT);
        end
    end

    // certification: odd parity keeps the state, else flip lowest parity bit
    assign pand = e0_reg & parities;
    assign par  = ^pand;
    assign flip = parities & (~parities + 128'd1);
    assign certe = par ? e0_reg : (e0_reg ^ flip);

    assign wsel = pos_reg[1:0];

    always_comb
    begin
        widx_next   = widx_reg;
        prev_next   = prev_reg;
        prod_next   = prod_reg;
        lanes_next  = lanes_reg;
        e0_next     = e0_reg;
        ri_next     = ri_reg;
        bi_next     = bi_reg;
        r1_next     = r1_reg;
        r2_next     = r2_reg;
        pos_next    = pos_reg;
        wvalid_next = 1'b0;
        sdone_next  = 1'b0;
        gdone_next  = 1'b0;
        we          = 1'b0;
        waddr       = ri_reg;
        wdata       = newe;
        raddr_a     = ri_reg;
        raddr_b     = bi_reg;
        case (cmd.op)
            DP_SEED_START:
            begin
                prev_next  = seed;
                prod_next  = seed;
                widx_next  = '0;
                lanes_next = {64'd0, seed};
                pos_next   = WORDS_P;
            end
            DP_SEED_STEP:
            begin
                prod_next = 32'(SEED_MULT * mixed);
            end
            DP_SEED_WRITE:
            begin
                // prod_reg holds word widx_reg + 1 before the index add
                if (widx_reg[1:0] == 2'd3)
                begin
                    we    = 1'b1;
                    waddr = AW'(widx_reg >> 2);
                    wdata = {prev_reg, lanes_reg};
                    if (widx_reg == WAW'(3))
                    begin
                        e0_next = {prev_reg, lanes_reg};
                    end
                end
                if (widx_reg == LAST_WORD)
                begin
                    sdone_next = 1'b1;
                end
                else
                begin
                    widx_next = widx_reg + WAW'(1);
                    prev_next = prod_reg + 32'(widx_reg + WAW'(1));
                    case (widx_next[1:0])
                        2'd0:    lanes_next = {64'd0, prev_next};
                        2'd1:    lanes_next[63:32] = prev_next;
                        2'd2:    lanes_next[95:64] = prev_next;
                        default: ;
                    endcase
                end
            end
            DP_CERT:
            begin
                we    = 1'b1;
                waddr = '0;
                wdata = certe;
            end
            DP_REGEN_READ:
            begin
                if (cmd.first)
                begin
                    ri_next = '0;
                    bi_next = PICK_A;
                    r1_next = r1_pre;
                    r2_next = r2_pre;
                end
                raddr_a = cmd.first ? '0 : ri_reg;
                raddr_b = cmd.first ? PICK_A : bi_reg;
            end
            DP_REGEN_WRITE:
            begin
                we      = 1'b1;
                waddr   = ri_reg;
                wdata   = newe;
                r1_next = r2_reg;
                r2_next = newe;
                ri_next = (ri_reg == LAST_ENTRY) ? '0 : ri_reg + AW'(1);
                bi_next = (bi_reg == LAST_ENTRY) ? '0 : bi_reg + AW'(1);
                if (ri_reg == LAST_ENTRY)
                begin
                    gdone_next = 1'b1;
                    pos_next   = '0;
                end
            end
            DP_DRAW:
            begin
                raddr_a     = AW'(pos_reg >> 2);
                pos_next    = pos_reg + PW'(1);
                wvalid_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_DRAW)
        begin
            dsel_reg <= wsel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvalid_reg <= 1'b0;
            sdone_reg  <= 1'b0;
            gdone_reg  <= 1'b0;
            pos_reg    <= WORDS_P;
        end
        else
        begin
            wvalid_reg <= wvalid_next;
            sdone_reg  <= sdone_next;
            gdone_reg  <= gdone_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        widx_reg  <= widx_next;
        prev_reg  <= prev_next;
        prod_reg  <= prod_next;
        lanes_reg <= lanes_next;
        e0_reg    <= e0_next;
        ri_reg    <= ri_next;
        bi_reg    <= bi_next;
        r1_reg    <= r1_next;
        r2_reg    <= r2_next;
    end

    // neighbors c, d of entry 0 are the last two entries before the sweep;
    // keep copies of them as they are written
    always_ff @(posedge clk)
    begin
        if (we && waddr == PRELAST)
        begin
            r1_pre <= wdata;
        end
        if (we && waddr == LAST_ENTRY)
        begin
            r2_pre <= wdata;
        end
    end

    assign status.seed_done  = sdone_reg;
    assign status.regen_done = gdone_reg;
    assign status.need_regen = (pos_reg >= WORDS_P);
    assign status.word_valid = wvalid_reg;
    assign word = rdata_a[32*dsel_reg +: 32];
endmodule

### rtl/core/sfmt_ctrl.sv
// Controller: sequences reseed, regeneration and draws.
module sfmt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_op,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_load,
    output logic                 seed_sel,
    output sfmt_pkg::dp_cmd_t    cmd,
    input  sfmt_pkg::dp_status_t status
);
    import sfmt_pkg::*;

    typedef enum logic [8:0] {
        S_BOOT   = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_SSTEP  = 9'b000000100,
        S_SWRITE = 9'b000001000,
        S_CERT   = 9'b000010000,
        S_GREAD  = 9'b000100000,
        S_GWRITE = 9'b001000000,
        S_DRAW   = 9'b010000000,
        S_DWAIT  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   first_reg, first_next;
    logic   ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        ov_next    = ov_reg;
        cmd.op     = DP_NOP;
        cmd.first  = 1'b0;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        seed_sel   = 1'b0;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_BOOT:
            begin
                seed_sel   = 1'b1;
                cmd.op     = DP_SEED_START;
                state_next = S_SSTEP;
            end
            S_IDLE:
            begin
                in_ready = !ov_reg || out_ready;
                if (in_valid && in_ready)
                begin
                    if (in_op == OP_RESEED)
                    begin
                        cmd.op     = DP_SEED_START;
                        state_next = S_SSTEP;
                    end
                    else if (status.need_regen)
                    begin
                        state_next = S_GREAD;
                        first_next = 1'b1;
                    end
                    else
                    begin
                        cmd.op     = DP_DRAW;
                        state_next = S_DWAIT;
                    end
                end
            end
            S_SSTEP:
            begin
                if (status.seed_done)
                begin
                    state_next = S_CERT;
                end
                else
                begin
                    cmd.op     = DP_SEED_STEP;
                    state_next = S_SWRITE;
                end
            end
            S_SWRITE:
            begin
                cmd.op     = DP_SEED_WRITE;
                state_next = S_SSTEP;
            end
            S_CERT:
            begin
                cmd.op     = DP_CERT;
                state_next = S_IDLE;
            end
            S_GREAD:
            begin
                cmd.op     = DP_REGEN_READ;
                cmd.first  = first_reg;
                first_next = 1'b0;
                state_next = S_GWRITE;
            end
            S_GWRITE:
            begin
                cmd.op     = DP_REGEN_WRITE;
                state_next = S_DRAW;
            end
            S_DRAW:
            begin
                // an idle state lets the written entry settle before its reread;
                // after the last entry, issue the pending draw
                if (status.regen_done)
                begin
                    cmd.op     = DP_DRAW;
                    state_next = S_DWAIT;
                end
                else
                begin
                    state_next = S_GREAD;
                end
            end
            S_DWAIT:
            begin
                if (status.word_valid)
                begin
                    out_load   = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOOT;
            first_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;
endmodule

### rtl/core/sfmt_random_word_generator.sv
// Top level of the SFMT19937 32-bit random word generator.
//
// Input stream s_axis: tdata[31:0] seed_value, tuser[0] opcode (0 draw,
// 1 reseed). Output stream m_axis: tdata[31:0] random_word, one per draw.
// A reseed gives no output.
// Configuration: cfg_we with cfg_index 0..3 writes the recursion masks,
// 4..7 the parity words; writes take effect at the next reseed or
// regeneration. The user must make them only while the block is idle; the block itself does not enforce this.
// Timing: a draw is the state RAM read, then the load of the
// output register. Every 624 draws the first draw also regenerates all
// 156 entries, each by read, recurse and write, settle. A reseed runs
// the seed recurrence one word at a time (multiplier then add). One
// item is in work at a time.
// Reset: the state is filled as if seeded with 1234, during which no
// item is accepted.
// Stall: a result waits in the output register; the next item is taken
// as soon as the waiting result is taken or in the same cycle.
module sfmt_random_word_generator #(
    parameter int STORE_DEPTH      = 156,
    parameter int PICK_OFFSET      = 122,
    parameter int WORD_SHIFT_LEFT  = 18,
    parameter int BYTE_SHIFT_LEFT  = 1,
    parameter int WORD_SHIFT_RIGHT = 11,
    parameter int BYTE_SHIFT_RIGHT = 1
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] seed_value
    input  logic        s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] random_word
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import sfmt_pkg::*;

    logic [127:0] mask_reg, parity_reg;
    logic [31:0]  out_reg;
    logic [31:0]  seed;
    logic [31:0]  word;
    logic         out_load, seed_sel;
    dp_cmd_t      cmd;
    dp_status_t   status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= {MASK3_RST, MASK2_RST, MASK1_RST, MASK0_RST};
            parity_reg <= {PARITY3_RST, PARITY2_RST, PARITY1_RST, PARITY0_RST};
        end
        else if (cfg_we)
        begin
            if (cfg_index < REG_PARITY0)
            begin
                mask_reg[32*(cfg_index[1:0] - REG_MASK0[1:0]) +: 32] <= cfg_wdata;
            end
            else
            begin
                parity_reg[32*cfg_index[1:0] +: 32] <= cfg_wdata;
            end
        end
    end

    assign seed = seed_sel ? RESET_SEED : s_axis_tdata;

    sfmt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_op(s_axis_tuser), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_load(out_load), .seed_sel(seed_sel), .cmd(cmd), .status(status)
    );

    sfmt_datapath #(
        .STORE_DEPTH(STORE_DEPTH), .PICK_OFFSET(PICK_OFFSET),
        .WORD_SHIFT_LEFT(WORD_SHIFT_LEFT), .BYTE_SHIFT_LEFT(BYTE_SHIFT_LEFT),
        .WORD_SHIFT_RIGHT(WORD_SHIFT_RIGHT), .BYTE_SHIFT_RIGHT(BYTE_SHIFT_RIGHT)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status), .seed(seed),
        .masks(mask_reg), .parities(parity_reg), .word(word)
    );

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= word;
        end
    end
    assign m_axis_tdata = out_reg;

    // a new result never overwrites one that waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten while stalled");

    // no draw is issued with draw data valid while a result waits and the receiver stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !(s_axis_tready && !m_axis_tready
            && cmd.op == DP_DRAW && status.word_valid))
        else $error("draw issued into stalled output");

    // output valid rises only after a load
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(out_load))
        else $error("output valid without load");
endmodule

### dv/tb_sfmt_random_word_generator.sv
// Testbench for the SFMT19937 random word generator: stream stimulus, predictor and checker.
`timescale 1ns / 100ps

module tb_sfmt_random_word_generator;
    import sfmt_pkg::*;

    localparam int DEPTH      = 156;
    localparam int WORDS      = 4 * DEPTH;
    localparam int PICK       = 122;
    localparam int SL         = 18;
    localparam int SR         = 11;
    localparam int CYCLE_CAP  = 2000000;
    localparam int SETTLE     = 1500;

    typedef struct packed {
        logic        op;
        logic [31:0] seed;
    } gen_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;

    sfmt_random_word_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // predictor state
    logic [31:0] pool [WORDS];
    int          pool_pos;
    logic [31:0] mask_reg [4];
    logic [31:0] parity_reg [4];

    gen_item_t   pending_items [$];
    logic [31:0] expected_words [$];
    int          errors;
    int          draws_seen;
    int          reseeds_sent;
    int          cycles;
    bit          hold_off;

    function automatic void fill_pool(logic [31:0] seed);
        logic [31:0] acc;
        logic [31:0] p;
        bit          done;
        pool[0] = seed;
        for (int i = 1; i < WORDS; i++) begin
            p = pool[i-1];
            pool[i] = SEED_MULT * (p ^ (p >> 30)) + i;
        end
        pool_pos = WORDS;
        acc = 0;
        for (int i = 0; i < 4; i++)
            acc ^= pool[i] & parity_reg[i];
        if (^acc)
            return;
        done = 0;
        for (int i = 0; i < 4 && !done; i++)
            for (int j = 0; j < 32 && !done; j++)
                if (parity_reg[i][j]) begin
                    pool[i][j] = ~pool[i][j];
                    done = 1;
                end
    endfunction

    function automatic logic [127:0] entry(int k);
        return {pool[4*k+3], pool[4*k+2], pool[4*k+1], pool[4*k]};
    endfunction

    function automatic void regenerate_pool();
        int r1;
        int r2;
        int bi;
        logic [127:0] a;
        logic [127:0] x;
        logic [127:0] y;
        logic [127:0] b;
        logic [127:0] d;
        logic [31:0]  lane;
        r1 = DEPTH - 2;
        r2 = DEPTH - 1;
        for (int i = 0; i < DEPTH; i++) begin
            bi = (i + PICK) % DEPTH;
            a = entry(i);
            b = entry(bi);
            d = entry(r2);
            x = a << 8;
            y = entry(r1) >> 8;
            for (int j = 0; j < 4; j++) begin
                lane = a[32*j +: 32] ^ x[32*j +: 32] ^ ((b[32*j +: 32] >> SR) & mask_reg[j])
                       ^ y[32*j +: 32] ^ (d[32*j +: 32] << SL);
                pool[4*i+j] = lane;
            end
            r1 = r2;
            r2 = i;
        end
    endfunction

    function automatic void predict_item(gen_item_t it);
        if (it.op == OP_RESEED) begin
            fill_pool(it.seed);
            return;
        end
        if (pool_pos >= WORDS) begin
            regenerate_pool();
            pool_pos = 0;
        end
        expected_words.push_back(pool[pool_pos]);
        pool_pos++;
    endfunction

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // sender: bursts of random length with random gaps
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= OP_DRAW;
            burst_left    <= 0;
            gap_left      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_item({s_axis_tuser, s_axis_tdata});
                if (s_axis_tuser == OP_RESEED)
                    reseeds_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= pending_items[0].op;
                    s_axis_tdata  <= pending_items[0].seed;
                    void'(pending_items.pop_front());
                    if (burst_left <= 0) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: own stall pattern, plus a long hold-off when requested
    int stall_mode;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            stall_mode    <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                draws_seen++;
                if (expected_words.size() == 0) begin
                    $error("unexpected word %h", m_axis_tdata);
                    errors++;
                end else begin
                    if (m_axis_tdata !== expected_words[0]) begin
                        $error("random_word expected %h actual %h",
                               expected_words[0], m_axis_tdata);
                        errors++;
                    end
                    void'(expected_words.pop_front());
                end
            end
            if ($urandom_range(0, 199) == 0)
                stall_mode <= $urandom_range(0, 2);
            if (hold_off)
                m_axis_tready <= 1'b0;
            else
                case (stall_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx < REG_PARITY0)
            mask_reg[idx[1:0]] = val;
        else
            parity_reg[idx[1:0]] = val;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_words.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic add_draws(int n);
        for (int i = 0; i < n; i++)
            pending_items.push_back('{OP_DRAW, $urandom});
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 2)
                pending_items.push_back('{OP_RESEED, $urandom});
            else
                pending_items.push_back('{OP_DRAW, $urandom});
        end
    endtask

    initial
    begin
        logic [31:0] v;
        errors = 0; draws_seen = 0; reseeds_sent = 0; cycles = 0; hold_off = 0;
        cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
        mask_reg   = '{MASK0_RST, MASK1_RST, MASK2_RST, MASK3_RST};
        parity_reg = '{PARITY0_RST, PARITY1_RST, PARITY2_RST, PARITY3_RST};
        fill_pool(RESET_SEED);
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: draws from the reset state, seed extremes
        add_draws(4);
        pending_items.push_back('{OP_RESEED, 32'h0});
        add_draws(3);
        pending_items.push_back('{OP_RESEED, 32'hffffffff});
        add_draws(3);
        pending_items.push_back('{OP_RESEED, 32'h5555aaaa});
        pending_items.push_back('{OP_RESEED, 32'haaaa5555});
        add_draws(2);
        drain();

        // all parity zero: even parity, nothing flipped; masks zero
        for (int i = 0; i < 8; i++)
            write_reg(i[2:0], 32'h0);
        pending_items.push_back('{OP_RESEED, 32'd1});
        add_draws(5);
        drain();

        // all ones, then a parity bit high up so the fix lands in a later word
        for (int i = 0; i < 8; i++)
            write_reg(i[2:0], 32'hffffffff);
        pending_items.push_back('{OP_RESEED, 32'd7});
        add_draws(3);
        drain();
        write_reg(REG_PARITY0, 32'h0);
        write_reg(REG_PARITY0 + 3'd1, 32'h0);
        write_reg(REG_PARITY0 + 3'd2, 32'h80000000);
        pending_items.push_back('{OP_RESEED, 32'd9});
        add_draws(2);
        drain();

        // random phases under several settings, back to defaults last
        for (int ph = 0; ph < 3; ph++) begin
            for (int i = 0; i < 8; i++) begin
                v = $urandom;
                write_reg(i[2:0], v);
            end
            if (ph == 1) begin
                // hold the receiver off while the sender keeps offering
                hold_off = 1;
                random_phase(20);
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            random_phase(420);
            drain();
        end
        write_reg(REG_MASK0, MASK0_RST);
        write_reg(REG_MASK0 + 3'd1, MASK1_RST);
        write_reg(REG_MASK0 + 3'd2, MASK2_RST);
        write_reg(REG_MASK0 + 3'd3, MASK3_RST);
        write_reg(REG_PARITY0, PARITY0_RST);
        write_reg(REG_PARITY0 + 3'd1, PARITY1_RST);
        write_reg(REG_PARITY0 + 3'd2, PARITY2_RST);
        write_reg(REG_PARITY0 + 3'd3, PARITY3_RST);
        pending_items.push_back('{OP_RESEED, $urandom});
        random_phase(430);
        drain();

        $display("Run: %0d words checked, %0d reseeds, across default, zero, all-ones and random",
                 draws_seen, reseeds_sent);
        $display("     mask and parity settings, with regenerations and a long output stall.");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/core/sfmt_pkg.sv
rtl/core/sfmt_ram.sv
rtl/core/sfmt_datapath.sv
rtl/core/sfmt_ctrl.sv
rtl/core/sfmt_random_word_generator.sv
dv/tb_sfmt_random_word_generator.sv
